// ===== rtl/lgs_pkg.sv =====
// Shared sizes, types and cell-rule functions of the Life generation stream unit.
`default_nettype none

package lgs_pkg;

   localparam int WORD_CELLS     = 16;
   localparam int MAX_ROW_WORDS  = 8;
   localparam int MAX_ROWS       = 1024;
   localparam int MAX_WIDTH      = MAX_ROW_WORDS * WORD_CELLS;
   localparam int CELL_BITS      = $clog2(WORD_CELLS);
   localparam int WORD_IDX_BITS  = $clog2(MAX_ROW_WORDS);
   localparam int WORD_CNT_BITS  = $clog2(MAX_ROW_WORDS + 1);
   localparam int ROW_IDX_BITS   = $clog2(MAX_ROWS);
   localparam int ROW_CNT_BITS   = $clog2(MAX_ROWS + 1);
   localparam int WIDTH_BITS     = 8;
   localparam int HEIGHT_BITS    = 11;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [WORD_CELLS-1:0]     word_type;
   typedef logic [WORD_CELLS+1:0]     window_type;
   typedef logic [WORD_IDX_BITS-1:0]  word_idx_type;
   typedef logic [WORD_CNT_BITS-1:0]  word_cnt_type;
   typedef logic [ROW_IDX_BITS-1:0]   row_idx_type;
   typedef logic [ROW_CNT_BITS-1:0]   row_cnt_type;
   typedef logic [WIDTH_BITS-1:0]     width_type;
   typedef logic [HEIGHT_BITS-1:0]    height_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;
   typedef logic [3:0]                count_type;

   localparam csr_index_type CSR_GRID_WIDTH  = csr_index_type'(0);
   localparam csr_index_type CSR_GRID_HEIGHT = csr_index_type'(1);

   localparam width_type  RESET_GRID_WIDTH  = width_type'(120);
   localparam height_type RESET_GRID_HEIGHT = height_type'(75);

   // B3/S23: a dead cell with three neighbors is born, a live one with two or three survives.
   localparam count_type LIFE_BIRTH   = count_type'(3);
   localparam count_type LIFE_SURVIVE = count_type'(2);

   // Work phases of one input word.
   typedef enum logic [1:0] {
      PH_INNER,
      PH_EDGE,
      PH_FLUSH
   } phase_type;

   typedef struct packed {
      word_type     next_cells;
      row_idx_type  row_index;
      word_idx_type word_index;
      logic         last_of_frame;
   } rsp_type;

   function automatic width_type clip_width(input width_type raw);
      width_type eff;
      eff = raw;
      if (raw == '0) begin
         eff = width_type'(1);
      end else if (raw > width_type'(MAX_WIDTH)) begin
         eff = width_type'(MAX_WIDTH);
      end
      return eff;
   endfunction

   function automatic word_cnt_type words_of(input width_type eff);
      logic [WIDTH_BITS:0] sum;
      sum = {1'b0, eff} + (WIDTH_BITS + 1)'(WORD_CELLS - 1);
      return word_cnt_type'(sum >> CELL_BITS);
   endfunction

   function automatic row_cnt_type clip_height(input height_type raw);
      row_cnt_type eff;
      eff = row_cnt_type'(raw);
      if (raw == '0) begin
         eff = row_cnt_type'(1);
      end else if (row_cnt_type'(raw) > row_cnt_type'(MAX_ROWS)) begin
         eff = row_cnt_type'(MAX_ROWS);
      end
      return eff;
   endfunction

   // Bit i is set when column WORD_CELLS*col+i lies inside the grid.
   function automatic word_type cell_mask(input word_idx_type col, input width_type eff);
      word_type            mask;
      logic [WIDTH_BITS:0] pos;
      for (int i = 0; i < WORD_CELLS; i++) begin
         pos     = (WIDTH_BITS + 1)'({col, CELL_BITS'(i)});
         mask[i] = pos < {1'b0, eff};
      end
      return mask;
   endfunction

   // Centre word with one neighbor cell on each side; bit 0 is the left neighbor.
   function automatic window_type make_window(input word_type lft, input word_type ctr,
                                              input word_type rgt);
      return {rgt[0], ctr, lft[WORD_CELLS-1]};
   endfunction

   function automatic word_type life_word(input window_type up, input window_type mid,
                                          input window_type dn);
      word_type  res;
      count_type cnt;
      for (int i = 0; i < WORD_CELLS; i++) begin
         cnt = count_type'(up[i]) + count_type'(up[i+1]) + count_type'(up[i+2])
             + count_type'(mid[i]) + count_type'(mid[i+2])
             + count_type'(dn[i]) + count_type'(dn[i+1]) + count_type'(dn[i+2]);
         res[i] = (cnt == LIFE_BIRTH) || (mid[i+1] && (cnt == LIFE_SURVIVE));
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/life_generation_stream_unit.sv =====
// Top level of the Life generation stream unit: one B3/S23 generation over a streamed grid.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_cells
//   rsp_      out        rsp_valid / rsp_stall  rsp_next_cells, rsp_row_index,
//                                               rsp_word_index, rsp_last_of_frame
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A word that is not the last of its row needs only the inner phase, so a raster
// stream of such words is taken at one word per cycle unless the result side stalls. The
// last word of a row passes through an inner and an edge phase, since it yields two result
// words through the single output register. The last word of a frame then runs the flush,
// which sweeps the row buffers one word per cycle after a priming step that loads the
// neighbor window. Stalls on the result side hold the stage only when it has a result to
// hand over. Reset is synchronous and returns the grid size to 120 by 75 cells with dead row buffers.
`default_nettype none

module life_generation_stream_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lgs_pkg::word_type      req_cells,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lgs_pkg::word_type           rsp_next_cells,
   output lgs_pkg::row_idx_type        rsp_row_index,
   output lgs_pkg::word_idx_type       rsp_word_index,
   output logic                        rsp_last_of_frame,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire lgs_pkg::csr_index_type csr_index,
   input  wire lgs_pkg::csr_data_type  csr_wdata
);
   import lgs_pkg::*;

   // Configuration, kept in its clipped form.
   width_type    width_ff, width_in;
   word_cnt_type words_ff, words_in;
   row_cnt_type  rows_ff, rows_in;

   // Input stage: the word being worked on and where it sits in the frame.
   logic         item_valid_ff, item_valid_in;
   word_type     cells_ff, cells_in;
   phase_type    phase_ff, phase_in;
   word_idx_type word_ff, word_in;
   row_idx_type  row_ff, row_in;
   word_cnt_type flush_ff, flush_in;

   // Row buffers: upper holds two rows back, middle one row back, per word column.
   word_type upper_ff [MAX_ROW_WORDS];
   word_type upper_in [MAX_ROW_WORDS];
   word_type middle_ff [MAX_ROW_WORDS];
   word_type middle_in [MAX_ROW_WORDS];

   // Left-hand neighbor words of the current column: entry 0 is two columns back,
   // entry 1 one column back. The dn window holds the words of the row arriving now.
   word_type up_win_ff [2];
   word_type up_win_in [2];
   word_type mid_win_ff [2];
   word_type mid_win_in [2];
   word_type dn_win_ff [2];
   word_type dn_win_in [2];

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic         cfg_wr;
   logic         cfg_hit;
   width_type    new_width;
   logic         accept;
   logic         last_word;
   logic         last_row;
   word_type     cells_live;
   word_cnt_type rd_idx;
   logic         rd_ok;
   word_type     up_rd;
   word_type     mid_rd;
   word_idx_type wm1;
   word_idx_type wm2;
   logic         has_out;
   window_type   up_w;
   window_type   mid_w;
   window_type   dn_w;
   word_idx_type out_col;
   row_idx_type  out_row;
   logic         out_last;
   logic         out_free;
   logic         step;
   logic         item_done;

   // Configuration writes. Only the two defined registers restart the frame.
   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;
   assign cfg_hit   = cfg_wr && ((csr_index == CSR_GRID_WIDTH) || (csr_index == CSR_GRID_HEIGHT));
   assign new_width = clip_width(csr_wdata[WIDTH_BITS-1:0]);

   always_comb begin
      width_in = width_ff;
      words_in = words_ff;
      rows_in  = rows_ff;
      if (cfg_wr && (csr_index == CSR_GRID_WIDTH)) begin
         width_in = new_width;
         words_in = words_of(new_width);
      end
      if (cfg_wr && (csr_index == CSR_GRID_HEIGHT)) begin
         rows_in = clip_height(csr_wdata[HEIGHT_BITS-1:0]);
      end
   end

   // Position of the word in the frame.
   assign last_word  = (word_cnt_type'(word_ff) + word_cnt_type'(1)) == words_ff;
   assign last_row   = (row_cnt_type'(row_ff) + row_cnt_type'(1)) == rows_ff;
   assign cells_live = cells_ff & cell_mask(word_ff, width_ff);
   assign wm1        = word_ff - word_idx_type'(1);
   assign wm2        = word_ff - word_idx_type'(2);

   // One row buffer read per cycle: the column of the incoming word, or during the flush
   // the column to the right of the word being produced. Columns past the row read dead.
   assign rd_idx = (phase_ff == PH_FLUSH) ? flush_ff : word_cnt_type'(word_ff);
   assign rd_ok  = rd_idx < words_ff;
   assign up_rd  = rd_ok ? upper_ff[rd_idx[WORD_IDX_BITS-1:0]] : '0;
   assign mid_rd = rd_ok ? middle_ff[rd_idx[WORD_IDX_BITS-1:0]] : '0;

   // Phase outputs: which neighborhood feeds the cell rule and where the result lands.
   // The inner phase finishes the word left of the incoming one in the previous row, the
   // edge phase the last word of that row, and the flush phase the final row against a
   // dead row below it. Flush count zero is the priming cycle and yields nothing.
   always_comb begin
      has_out  = 1'b0;
      up_w     = '0;
      mid_w    = '0;
      dn_w     = '0;
      out_col  = word_ff;
      out_row  = row_ff;
      out_last = 1'b0;
      case (phase_ff)
         PH_INNER: begin
            has_out = (word_ff != '0) && (row_ff != '0);
            up_w    = make_window(up_win_ff[0], up_win_ff[1], up_rd);
            mid_w   = make_window(mid_win_ff[0], mid_win_ff[1], mid_rd);
            dn_w    = make_window(dn_win_ff[0], dn_win_ff[1], cells_live);
            out_col = wm1;
            out_row = row_ff - row_idx_type'(1);
         end
         PH_EDGE: begin
            has_out = row_ff != '0;
            up_w    = make_window(up_win_ff[1], up_rd, '0);
            mid_w   = make_window(mid_win_ff[1], mid_rd, '0);
            dn_w    = make_window(dn_win_ff[1], cells_live, '0);
            out_col = word_ff;
            out_row = row_ff - row_idx_type'(1);
         end
         PH_FLUSH: begin
            has_out  = flush_ff != '0;
            up_w     = make_window(up_win_ff[0], up_win_ff[1], up_rd);
            mid_w    = make_window(mid_win_ff[0], mid_win_ff[1], mid_rd);
            out_col  = word_idx_type'(flush_ff - word_cnt_type'(1));
            out_row  = row_ff;
            out_last = flush_ff == words_ff;
         end
         default: begin
            has_out = 1'b0;
         end
      endcase
   end

   // The stage moves on when it has nothing to hand over or the result register frees up.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = item_valid_ff && (!has_out || out_free);
   assign item_done = step && (((phase_ff == PH_INNER) && !last_word)
                            || ((phase_ff == PH_EDGE) && !last_row)
                            || ((phase_ff == PH_FLUSH) && (flush_ff == words_ff)));

   // A new word enters as the current one finishes, so plain words stream back to back.
   assign req_stall     = item_valid_ff && !item_done;
   assign accept        = req_valid && !req_stall;
   assign item_valid_in = accept || (item_valid_ff && !item_done);
   assign cells_in      = accept ? req_cells : cells_ff;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_INNER: begin
               if (last_word) begin
                  phase_in = PH_EDGE;
               end
            end
            PH_EDGE: begin
               if (last_row) begin
                  phase_in = PH_FLUSH;
               end
            end
            PH_FLUSH: begin
               phase_in = PH_FLUSH;
            end
            default: begin
               phase_in = PH_INNER;
            end
         endcase
      end
      if (item_done || cfg_hit) begin
         phase_in = PH_INNER;
      end
   end

   // Frame position, row buffers and neighbor windows. A column of the row buffers is
   // retired (middle moves to upper, the new word to middle) once no result still needs
   // its old contents; the windows keep those old contents for the words to the right.
   always_comb begin
      word_in    = word_ff;
      row_in     = row_ff;
      flush_in   = flush_ff;
      upper_in   = upper_ff;
      middle_in  = middle_ff;
      up_win_in  = up_win_ff;
      mid_win_in = mid_win_ff;
      dn_win_in  = dn_win_ff;
      if (cfg_hit) begin
         word_in    = '0;
         row_in     = '0;
         flush_in   = '0;
         upper_in   = '{default: '0};
         middle_in  = '{default: '0};
         up_win_in  = '{default: '0};
         mid_win_in = '{default: '0};
         dn_win_in  = '{default: '0};
      end else if (step) begin
         case (phase_ff)
            PH_INNER: begin
               if (!last_word) begin
                  if (word_ff >= word_idx_type'(2)) begin
                     upper_in[wm2]  = mid_win_ff[0];
                     middle_in[wm2] = dn_win_ff[0];
                  end
                  up_win_in[0]  = up_win_ff[1];
                  up_win_in[1]  = up_rd;
                  mid_win_in[0] = mid_win_ff[1];
                  mid_win_in[1] = mid_rd;
                  dn_win_in[0]  = dn_win_ff[1];
                  dn_win_in[1]  = cells_live;
                  word_in       = word_ff + word_idx_type'(1);
               end
            end
            PH_EDGE: begin
               if (word_ff >= word_idx_type'(2)) begin
                  upper_in[wm2]  = mid_win_ff[0];
                  middle_in[wm2] = dn_win_ff[0];
               end
               if (word_ff != '0) begin
                  upper_in[wm1]  = mid_win_ff[1];
                  middle_in[wm1] = dn_win_ff[1];
               end
               upper_in[word_ff]  = mid_rd;
               middle_in[word_ff] = cells_live;
               up_win_in          = '{default: '0};
               mid_win_in         = '{default: '0};
               dn_win_in          = '{default: '0};
               if (last_row) begin
                  flush_in = '0;
               end else begin
                  row_in  = row_ff + row_idx_type'(1);
                  word_in = '0;
               end
            end
            PH_FLUSH: begin
               if (flush_ff == words_ff) begin
                  // Frame complete: the next word starts a new generation.
                  word_in    = '0;
                  row_in     = '0;
                  flush_in   = '0;
                  upper_in   = '{default: '0};
                  middle_in  = '{default: '0};
                  up_win_in  = '{default: '0};
                  mid_win_in = '{default: '0};
                  dn_win_in  = '{default: '0};
               end else begin
                  flush_in      = flush_ff + word_cnt_type'(1);
                  up_win_in[0]  = up_win_ff[1];
                  up_win_in[1]  = up_rd;
                  mid_win_in[0] = mid_win_ff[1];
                  mid_win_in[1] = mid_rd;
               end
            end
            default: begin
               flush_in = flush_ff;
            end
         endcase
      end
   end

   // Result register: the cell rule, with columns past the grid forced dead.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step && has_out) begin
         rsp_in.next_cells    = life_word(up_w, mid_w, dn_w) & cell_mask(out_col, width_ff);
         rsp_in.row_index     = out_row;
         rsp_in.word_index    = out_col;
         rsp_in.last_of_frame = out_last;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= RESET_GRID_WIDTH;
         words_ff      <= words_of(RESET_GRID_WIDTH);
         rows_ff       <= clip_height(RESET_GRID_HEIGHT);
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_INNER;
         word_ff       <= '0;
         row_ff        <= '0;
         flush_ff      <= '0;
         upper_ff      <= '{default: '0};
         middle_ff     <= '{default: '0};
         up_win_ff     <= '{default: '0};
         mid_win_ff    <= '{default: '0};
         dn_win_ff     <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         words_ff      <= words_in;
         rows_ff       <= rows_in;
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         word_ff       <= word_in;
         row_ff        <= row_in;
         flush_ff      <= flush_in;
         upper_ff      <= upper_in;
         middle_ff     <= middle_in;
         up_win_ff     <= up_win_in;
         mid_win_ff    <= mid_win_in;
         dn_win_ff     <= dn_win_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_cells    = rsp_ff.next_cells;
   assign rsp_row_index     = rsp_ff.row_index;
   assign rsp_word_index    = rsp_ff.word_index;
   assign rsp_last_of_frame = rsp_ff.last_of_frame;

endmodule

`default_nettype wire

// ===== rtl/lgs_checker.sv =====
// Port-level checks of the Life generation stream unit, bound to its top level.
`default_nettype none

module lgs_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire lgs_pkg::word_type      req_cells,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire lgs_pkg::word_type      rsp_next_cells,
   input wire lgs_pkg::row_idx_type   rsp_row_index,
   input wire lgs_pkg::word_idx_type  rsp_word_index,
   input wire logic                   rsp_last_of_frame,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire lgs_pkg::csr_index_type csr_index,
   input wire lgs_pkg::csr_data_type  csr_wdata
);
   import lgs_pkg::*;

   logic    rsp_fire;
   rsp_type rsp_seen;

   assign rsp_fire = rsp_valid && !rsp_stall;
   assign rsp_seen = '{next_cells: rsp_next_cells, row_index: rsp_row_index,
                       word_index: rsp_word_index, last_of_frame: rsp_last_of_frame};

   // A result held back by the consumer stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seen))
      else $error("result transaction changed while stalled");

   // Results leave in raster order: next word of the row, first word of the next row,
   // or the first word of a new frame after the last one.
   a_raster: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && $past(rsp_fire) && $past(!reset) |->
         ($past(rsp_last_of_frame) && (rsp_row_index == '0) && (rsp_word_index == '0))
      || (!$past(rsp_last_of_frame)
          && (((rsp_row_index == $past(rsp_row_index))
               && (rsp_word_index == $past(rsp_word_index) + 1))
           || ((rsp_row_index == $past(rsp_row_index) + 1) && (rsp_word_index == '0)))))
      else $error("result transactions out of raster order");

   // Nothing is offered in the first cycle after reset is released.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind life_generation_stream_unit lgs_checker u_lgs_checker (.*);

`default_nettype wire
